FILE: design/drumenv_pkg.sv
package drumenv_pkg;

    // operation codes carried on tuser
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // filter modes, the unused code behaves as high-pass
    localparam logic [1:0] FMODE_BYPASS   = 2'd0;
    localparam logic [1:0] FMODE_LOWPASS  = 2'd1;
    localparam logic [1:0] FMODE_HIGHPASS = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_AMP_DECAY       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSIENT_DECAY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_DECAY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COEFF    = 3'd4;

    // register reset values
    localparam logic [31:0] AMP_DECAY_RESET       = 32'd4292870144;
    localparam logic [31:0] TRANSIENT_DECAY_RESET = 32'd3865470566;
    localparam logic [31:0] PITCH_DECAY_RESET     = 32'd3865470566;
    localparam logic [14:0] FILTER_COEFF_RESET    = 15'd32767;

    // envelope and jitter constants
    localparam logic [31:0] FULL_SCALE  = 32'hFFFF_FFFF;
    localparam logic [31:0] SEED_INIT   = 32'hDEAD_BEEF;
    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_ADD     = 32'd1013904223;
    localparam logic [10:0] JITTER_MASK = 11'h7FF;
    localparam logic [14:0] Q15_ONE     = 15'd32767;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 128;

    // result item, lowest field last
    typedef struct packed {
        logic [OUT_TDATA_W-128+0:0] pad;
        logic signed [15:0]         sample_out;
        logic [14:0]                velocity;
        logic [31:0]                pitch_env;
        logic [31:0]                transient_env;
        logic [31:0]                amp_env;
    } out_item_t;

endpackage

FILE: design/drumenv_filter.sv
module drumenv_filter (
    input  logic signed [15:0] sample,
    input  logic signed [16:0] mem,
    input  logic [14:0]        coeff,
    input  logic [1:0]         mode,
    output logic signed [16:0] mem_new,
    output logic signed [15:0] y
);
    import drumenv_pkg::*;

    logic signed [17:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] step;
    logic signed [17:0] hp;
    logic signed [17:0] pick;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    always_comb
    begin
        diff    = {{2{sample[15]}}, sample} - {mem[16], mem};
        prod    = diff * $signed({1'b0, coeff});
        // arithmetic shift gives the floor
        step    = prod >>> 15;
        mem_new = mem + step[16:0];
        hp      = {{2{sample[15]}}, sample} - {mem_new[16], mem_new};
        if (mode == FMODE_LOWPASS)
            pick = {mem_new[16], mem_new};
        else
            pick = hp;
        y = sat16(pick);
    end

endmodule

FILE: design/drum_envelope_and_filter_core.sv
// an input request passes the input and result registers; throughput is one request per
// cycle unless m_tready stalls, set by the single-pass decay multipliers and filter
// three 32x32 decay multipliers run in parallel with the filter product in one stage
// reset: rst_n clears state asynchronously; envelopes and filter memory go to zero,
// seed to its initial value, velocity to full scale, registers to their defaults
module drum_envelope_and_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // trigger_level [0], sample_in [16:1], zero pad [23:17]
    input  logic [drumenv_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation [0]
    input  logic                                s_tuser,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // amp_env [31:0], transient_env [63:32], pitch_env [95:64],
    // velocity [110:96], sample_out [126:111], zero pad [127]
    output logic [drumenv_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drumenv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);
    import drumenv_pkg::*;

    // configuration registers
    logic [31:0] amp_factor_reg;
    logic [31:0] trn_factor_reg;
    logic [31:0] pit_factor_reg;
    logic [1:0]  fmode_reg;
    logic [14:0] fcoeff_reg;

    // input register
    logic               in_valid_reg;
    logic               in_op_reg;
    logic               in_trig_reg;
    logic signed [15:0] in_sample_reg;

    // voice state
    logic               prev_trig_reg;
    logic [31:0]        amp_reg;
    logic [31:0]        trn_reg;
    logic [31:0]        pit_reg;
    logic [31:0]        seed_reg;
    logic [14:0]        vel_reg;
    logic signed [16:0] fmem_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_reg;

    // datapath
    logic               advance;
    logic               process;
    logic               is_tick;
    logic               trig_edge;
    logic [31:0]        amp_src;
    logic [31:0]        trn_src;
    logic [31:0]        pit_src;
    logic [63:0]        amp_prod;
    logic [63:0]        trn_prod;
    logic [63:0]        pit_prod;
    logic [31:0]        amp_next;
    logic [31:0]        trn_next;
    logic [31:0]        pit_next;
    logic [31:0]        seed_next;
    logic [14:0]        vel_next;
    logic signed [16:0] fmem_next;
    logic signed [16:0] filt_mem;
    logic signed [15:0] filt_y;
    logic signed [15:0] y;
    out_item_t          out_next;

    // result register frees up when empty or being taken
    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    drumenv_filter u_filter (
        .sample  (in_sample_reg),
        .mem     (fmem_reg),
        .coeff   (fcoeff_reg),
        .mode    (fmode_reg),
        .mem_new (filt_mem),
        .y       (filt_y)
    );

    always_comb
    begin
        is_tick   = (in_op_reg == OP_TICK);
        trig_edge = is_tick && in_trig_reg && !prev_trig_reg;

        // a hit loads full scale before this tick's decay
        amp_src = trig_edge ? FULL_SCALE : amp_reg;
        trn_src = trig_edge ? FULL_SCALE : trn_reg;
        pit_src = trig_edge ? FULL_SCALE : pit_reg;

        amp_prod = {32'd0, amp_src} * {32'd0, amp_factor_reg};
        trn_prod = {32'd0, trn_src} * {32'd0, trn_factor_reg};
        pit_prod = {32'd0, pit_src} * {32'd0, pit_factor_reg};

        // lcg step and velocity jitter from bits 26..16 of the new seed
        seed_next = seed_reg * LCG_MUL + LCG_ADD;
        vel_next  = Q15_ONE - {4'd0, seed_next[26:16] & JITTER_MASK};

        amp_next  = amp_reg;
        trn_next  = trn_reg;
        pit_next  = pit_reg;
        fmem_next = fmem_reg;
        y         = 16'sd0;

        if (is_tick)
        begin
            amp_next = amp_prod[63:32];
            trn_next = trn_prod[63:32];
            pit_next = pit_prod[63:32];
            if (trig_edge)
                fmem_next = 17'sd0;
        end
        else if (fmode_reg == FMODE_BYPASS)
        begin
            y = in_sample_reg;
        end
        else
        begin
            fmem_next = filt_mem;
            y         = filt_y;
        end

        out_next.pad           = '0;
        out_next.sample_out    = y;
        out_next.velocity      = trig_edge ? vel_next : vel_reg;
        out_next.pitch_env     = pit_next;
        out_next.transient_env = trn_next;
        out_next.amp_env       = amp_next;
    end

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_factor_reg <= AMP_DECAY_RESET;
            trn_factor_reg <= TRANSIENT_DECAY_RESET;
            pit_factor_reg <= PITCH_DECAY_RESET;
            fmode_reg      <= FMODE_BYPASS;
            fcoeff_reg     <= FILTER_COEFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AMP_DECAY:       amp_factor_reg <= cfg_data;
                REG_TRANSIENT_DECAY: trn_factor_reg <= cfg_data;
                REG_PITCH_DECAY:     pit_factor_reg <= cfg_data;
                REG_FILTER_MODE:     fmode_reg      <= cfg_data[1:0];
                REG_FILTER_COEFF:    fcoeff_reg     <= cfg_data[14:0];
                default:             ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= s_tuser;
            in_trig_reg   <= s_tdata[0];
            in_sample_reg <= s_tdata[16:1];
        end
    end

    // voice state moves once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_trig_reg <= 1'b0;
            amp_reg       <= '0;
            trn_reg       <= '0;
            pit_reg       <= '0;
            seed_reg      <= SEED_INIT;
            vel_reg       <= Q15_ONE;
            fmem_reg      <= '0;
        end
        else if (process)
        begin
            amp_reg  <= amp_next;
            trn_reg  <= trn_next;
            pit_reg  <= pit_next;
            fmem_reg <= fmem_next;
            if (is_tick)
                prev_trig_reg <= in_trig_reg;
            if (trig_edge)
            begin
                seed_reg <= seed_next;
                vel_reg  <= vel_next;
            end
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (process)
            out_reg <= out_next;
    end

    // velocity never drops below full scale minus the jitter range
    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        vel_reg[14:11] == 4'hF)
        else $error("velocity gain out of range");

    // filter memory stays inside the 16-bit sample range
    a_fmem_range: assert property (@(posedge clk) disable iff (!rst_n)
        fmem_reg[16] == fmem_reg[15])
        else $error("filter memory left sample range");

    // a hit leaves the amplitude envelope one below a nonzero decay factor, else zero
    a_hit_amp: assert property (@(posedge clk) disable iff (!rst_n)
        (process && trig_edge && !cfg_valid) |=>
            (amp_reg == ((amp_factor_reg == 32'd0) ? 32'd0 : amp_factor_reg - 32'd1)))
        else $error("envelope after hit mismatch");

    // an empty result register never blocks the slave side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("slave side stalled with result register empty");

endmodule

FILE: dv/drum_voice_monitor.sv
module drum_voice_monitor
    import drumenv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   end_of_run,
    output int                     outstanding,
    output int                     mismatch_total,
    output int                     voices_compared
);

    // shadow registers
    logic [31:0]        amp_k;
    logic [31:0]        trans_k;
    logic [31:0]        pitch_k;
    logic [1:0]         fmode;
    logic [14:0]        fcoeff;

    // voice state
    logic               armed_level;
    logic [31:0]        amp_lvl;
    logic [31:0]        trans_lvl;
    logic [31:0]        pitch_lvl;
    logic [31:0]        seed;
    logic [14:0]        vel;
    logic signed [16:0] filt_mem;

    out_item_t          predicted_voice[$];
    int                 mismatch_count = 0;
    bit                 leftovers_done = 1'b0;

    assign mismatch_total = mismatch_count;

    function automatic logic [31:0] decay_by(input logic [31:0] lvl, input logic [31:0] k);
        logic [63:0] prod;
        prod = {32'd0, lvl} * {32'd0, k};
        return prod[63:32];
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] voice mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
    endtask

    task automatic predict_voice(input logic op, input logic trig, input logic signed [15:0] smp);
        out_item_t r;
        int        x;
        int        mem_i;
        int        y;
        longint    prod;
        x     = smp;
        mem_i = filt_mem;
        y     = 0;
        if (op == OP_TICK)
        begin
            // only a rising trigger edge starts a hit
            if (trig && !armed_level)
            begin
                amp_lvl   = FULL_SCALE;
                trans_lvl = FULL_SCALE;
                pitch_lvl = FULL_SCALE;
                filt_mem  = '0;
                seed      = seed * LCG_MUL + LCG_ADD;
                vel       = Q15_ONE - 15'(seed[26:16] & JITTER_MASK);
            end
            armed_level = trig;
            amp_lvl     = decay_by(amp_lvl, amp_k);
            trans_lvl   = decay_by(trans_lvl, trans_k);
            pitch_lvl   = decay_by(pitch_lvl, pitch_k);
        end
        else if (fmode == FMODE_BYPASS)
            y = x;
        else
        begin
            // arithmetic shift floors towards minus infinity
            prod     = longint'(x - mem_i) * longint'(fcoeff);
            mem_i    = mem_i + int'(prod >>> 15);
            filt_mem = 17'(mem_i);
            // the spare mode code behaves as high-pass
            y = (fmode == FMODE_LOWPASS) ? mem_i : x - mem_i;
        end
        r               = '0;
        r.amp_env       = amp_lvl;
        r.transient_env = trans_lvl;
        r.pitch_env     = pitch_lvl;
        r.velocity      = vel;
        r.sample_out    = clamp16(y);
        predicted_voice.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            amp_k       = AMP_DECAY_RESET;
            trans_k     = TRANSIENT_DECAY_RESET;
            pitch_k     = PITCH_DECAY_RESET;
            fmode       = FMODE_BYPASS;
            fcoeff      = FILTER_COEFF_RESET;
            armed_level = 1'b0;
            amp_lvl     = '0;
            trans_lvl   = '0;
            pitch_lvl   = '0;
            seed        = SEED_INIT;
            vel         = Q15_ONE;
            filt_mem    = '0;
            predicted_voice.delete();
            outstanding     <= 0;
            voices_compared <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (predicted_voice.size() == 0)
                    flag_mismatch("result with nothing predicted");
                else
                begin
                    want = predicted_voice.pop_front();
                    check_field("amp_env", got.amp_env, want.amp_env);
                    check_field("transient_env", got.transient_env, want.transient_env);
                    check_field("pitch_env", got.pitch_env, want.pitch_env);
                    check_field("velocity", 32'(got.velocity), 32'(want.velocity));
                    check_field("sample_out", 32'(got.sample_out), 32'(want.sample_out));
                    voices_compared <= voices_compared + 1;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_AMP_DECAY:       amp_k   = cfg_data;
                    REG_TRANSIENT_DECAY: trans_k = cfg_data;
                    REG_PITCH_DECAY:     pitch_k = cfg_data;
                    REG_FILTER_MODE:     fmode   = cfg_data[1:0];
                    REG_FILTER_COEFF:    fcoeff  = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_voice(s_tuser, s_tdata[0], s_tdata[16:1]);
            if (end_of_run && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (predicted_voice.size() != 0)
                    flag_mismatch($sformatf("%0d predicted results never delivered",
                                            predicted_voice.size()));
            end
            outstanding <= predicted_voice.size();
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    import drumenv_pkg::*;

    // unused mode code, the block treats it as high-pass
    localparam logic [1:0] FMODE_SPARE    = 2'd3;
    localparam int         STALL_CYCLES   = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_PHASES  = 12;
    localparam int         PHASE_ITEMS    = 128;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic                   s_tuser    = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = REG_AMP_DECAY;
    logic [31:0]            cfg_data   = '0;
    logic                   end_of_run = 1'b0;

    int outstanding;
    int mismatch_total;
    int voices_compared;

    // state used across the stimulus, result-side and watchdog processes
    bit   idling_on   = 1'b1;
    bit   stall_req   = 1'b0;
    logic trig_level  = 1'b0;
    int   quiet_cycles = 0;

    // run statistics for the summary
    int tick_count    = 0;
    int hit_count     = 0;
    int sample_count  = 0;
    int setting_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    drum_envelope_and_filter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drum_voice_monitor voice_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .end_of_run      (end_of_run),
        .outstanding     (outstanding),
        .mismatch_total  (mismatch_total),
        .voices_compared (voices_compared)
    );

    // offer one request and hold it until the block takes it;
    // valid stays high into the next call unless a gap is rolled
    task automatic send_item(input logic op, input logic trig, input logic [15:0] smp);
        if (idling_on && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, smp, trig};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_SAMPLE)
            sample_count++;
        else
        begin
            tick_count++;
            if (trig && !trig_level)
                hit_count++;
            trig_level = trig;
        end
    endtask

    // stop offering and wait for every predicted result; the extra edge
    // lets the monitor register a request taken at the last edge
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // write all five registers back to back, only while the block is idle
    task automatic program_voice(input logic [31:0] amp_k, input logic [31:0] trans_k,
                                 input logic [31:0] pitch_k, input logic [31:0] mode_word,
                                 input logic [31:0] coeff_word);
        logic [CFG_INDEX_W-1:0] idx[5];
        logic [31:0]            val[5];
        idx = '{REG_AMP_DECAY, REG_TRANSIENT_DECAY, REG_PITCH_DECAY,
                REG_FILTER_MODE, REG_FILTER_COEFF};
        val = '{amp_k, trans_k, pitch_k, mode_word, coeff_word};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // decay factors: extremes now and then, mostly slow decays so envelopes live a while
    function automatic logic [31:0] pick_factor();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(32'hFFFF_FFFF, 32'hE000_0000);
        endcase
    endfunction

    // mode code in the low bits, sometimes with junk above it
    function automatic logic [31:0] pick_mode_word();
        logic [1:0]  modes[4];
        logic [31:0] w;
        modes  = '{FMODE_BYPASS, FMODE_LOWPASS, FMODE_HIGHPASS, FMODE_SPARE};
        w      = $urandom_range(0, 1) ? $urandom : 32'd0;
        w[1:0] = modes[$urandom_range(0, 3)];
        return w;
    endfunction

    function automatic logic [31:0] pick_coeff_word();
        logic [31:0] w;
        w = $urandom_range(0, 1) ? $urandom : 32'd0;
        case ($urandom_range(0, 4))
            0:       w[14:0] = 15'd0;
            1:       w[14:0] = 15'h7FFF;
            default: w[14:0] = 15'($urandom);
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random back-pressure, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end
            else
                m_tready <= !(idling_on && $urandom_range(0, 99) < 9);
        end
    end

    // watchdog: any request moving on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("drum_envelope_and_filter_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic next_trig;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, bypass: silent first tick, sample extremes and bit patterns,
        // a hit, a held trigger, release and a fresh hit
        send_item(OP_TICK,   1'b0, 16'h0000);
        send_item(OP_SAMPLE, 1'b1, 16'h7FFF);
        send_item(OP_SAMPLE, 1'b0, 16'h8000);
        send_item(OP_SAMPLE, 1'b1, 16'h5555);
        send_item(OP_SAMPLE, 1'b0, 16'hAAAA);
        send_item(OP_TICK,   1'b1, 16'hFFFF);
        send_item(OP_TICK,   1'b1, 16'h0000);
        send_item(OP_TICK,   1'b0, 16'h0000);
        send_item(OP_TICK,   1'b1, 16'h0000);

        // low-pass at full coefficient, decays at both extremes;
        // a hit in between clears the filter memory
        drain_results();
        program_voice(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, {30'd0, FMODE_LOWPASS}, 32'h7FFF);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF);
        send_item(OP_SAMPLE, 1'b0, 16'h8000);
        send_item(OP_TICK,   1'b0, 16'h0000);
        send_item(OP_TICK,   1'b1, 16'h0000);
        send_item(OP_SAMPLE, 1'b0, 16'h8000);

        // high-pass with a frozen memory near negative full scale: positive clipping
        drain_results();
        program_voice(32'hFFFF_FFFF, 32'h0, 32'h0, {30'd0, FMODE_HIGHPASS}, 32'h0);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF);
        send_item(OP_SAMPLE, 1'b1, 16'h8000);

        // spare mode code, must act as high-pass
        drain_results();
        program_voice(AMP_DECAY_RESET, TRANSIENT_DECAY_RESET, PITCH_DECAY_RESET,
                      {30'd0, FMODE_SPARE}, 32'h7FFF);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF);
        send_item(OP_SAMPLE, 1'b0, 16'h8000);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF);

        // memory left near positive full scale: negative clipping, then a hit
        drain_results();
        program_voice(AMP_DECAY_RESET, 32'hFFFF_FFFF, 32'h0, {30'd0, FMODE_HIGHPASS}, 32'h0);
        send_item(OP_SAMPLE, 1'b0, 16'h8000);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF);
        send_item(OP_TICK,   1'b0, 16'h0000);
        send_item(OP_TICK,   1'b1, 16'h0000);

        // random phases: drum hits and releases mixed with sample streams,
        // fresh register settings each phase
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // two phases run with neither side idling
            idling_on = !(p == 5 || p == 6);
            drain_results();
            program_voice(pick_factor(), pick_factor(), pick_factor(),
                          pick_mode_word(), pick_coeff_word());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one long hold-off on the result side while requests keep coming
                if (p == 2 && n == 20)
                    stall_req = 1'b1;
                if ($urandom_range(0, 99) < 55)
                    send_item(OP_SAMPLE, 1'($urandom_range(0, 1)), pick_sample());
                else
                begin
                    next_trig = ($urandom_range(0, 99) < 30) ? !trig_level : trig_level;
                    send_item(OP_TICK, next_trig, 16'($urandom));
                end
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d ticks with %0d trigger hits and %0d filter samples",
                 tick_count, hit_count, sample_count);
        $display("%0d register settings applied, %0d results compared",
                 setting_count, voices_compared);
        if (mismatch_total == 0)
            $display("drum_envelope_and_filter_core verification clean");
        else
            $display("drum_envelope_and_filter_core verification failed");
        $finish;
    end

endmodule
